// ===== design/pba_pkg.sv =====
// Shared constants, types and helper functions of the page bitmap allocator.
`default_nettype none

package pba_pkg;

    // Store geometry.
    localparam int NUM_PAGES        = 4096;
    localparam int PAGE_SHIFT       = 21;
    localparam int SMALL_PAGE_SHIFT = 12;
    localparam int RESET_USED       = 3;

    localparam int WORD_W      = 64;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int MAP_WORDS   = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int ROW_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLICE_W     = 8;
    localparam int SLICE_CNT   = WORD_W / SLICE_W;
    localparam int SLICE_IDX_W = $clog2(SLICE_W);
    localparam int SLICE_SEL_W = $clog2(SLICE_CNT);
    localparam int IDX_W       = ROW_W + BIT_IDX_W;
    localparam int END_W       = IDX_W + 1;

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 13;
    localparam int ADDR_W   = 52;
    localparam int TYPE_W   = 4;
    localparam int SMALL_W  = 40;
    localparam int STATUS_W = 2;
    localparam int EXT_W    = ADDR_W + 1;
    localparam int CMP_W    = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REGION = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd2;

    // Firmware memory types whose pages stay free.
    localparam logic [TYPE_W-1:0] TYPE_LOADER_CODE   = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_BOOT_SVC_CODE = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_BOOT_SVC_DATA = 4'd4;
    localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL  = 4'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN_RD,
        S_SCAN,
        S_FILL_RD,
        S_FILL_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic scan_rd;
        logic scan_step;
        logic fill_rd;
        logic fill_wr;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic slice_found;
        logic scan_end;
        logic slice_last;
        logic fill_pending;
        logic fill_last;
    } t_stat;

    function automatic logic type_is_free(input logic [TYPE_W-1:0] t);
        return (t == TYPE_LOADER_CODE) || (t == TYPE_BOOT_SVC_CODE) ||
               (t == TYPE_BOOT_SVC_DATA) || (t == TYPE_CONVENTIONAL);
    endfunction

    // Content of a bitmap row that has not been written since reset.
    function automatic logic [WORD_W-1:0] reset_word(input logic [ROW_W-1:0] row);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if ((int'(row) * WORD_W + j < RESET_USED) &&
                (int'(row) * WORD_W + j < NUM_PAGES)) begin
                w[j] = 1'b1;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/pba_ctrl.sv =====
// Controller state machine that sequences setup, bitmap search and marking.
`default_nettype none

module pba_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  pba_pkg::t_stat i_stat,
    output pba_pkg::t_cmd  o_cmd
);
    import pba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = i_stat.is_alloc ? S_SCAN_RD : S_FILL_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.slice_found) begin
                    n_state = S_FILL_RD;
                end else if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end else if (i_stat.slice_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_FILL_RD: begin
                n_state = i_stat.fill_pending ? S_FILL_WR : S_DONE;
            end
            S_FILL_WR: begin
                n_state = i_stat.fill_last ? S_DONE : S_FILL_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:    o_cmd.load      = start;
            S_SETUP:   o_cmd.setup     = 1'b1;
            S_SCAN_RD: o_cmd.scan_rd   = 1'b1;
            S_SCAN:    o_cmd.scan_step = 1'b1;
            S_FILL_RD: o_cmd.fill_rd   = i_stat.fill_pending;
            S_FILL_WR: o_cmd.fill_wr   = 1'b1;
            S_DONE:    o_cmd.done      = 1'b1;
            default:   o_cmd           = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result strobe not followed by idle");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.setup, o_cmd.scan_rd, o_cmd.scan_step,
                  o_cmd.fill_rd, o_cmd.fill_wr, o_cmd.done}))
        else $error("more than one datapath command in a cycle");

endmodule

`default_nettype wire

// ===== design/pba_datapath.sv =====
// Datapath: request registers, bitmap memory, slice search and row marking.
`default_nettype none

module pba_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  pba_pkg::t_cmd                    i_cmd,
    output pba_pkg::t_stat                   o_stat,
    input  wire [pba_pkg::KIND_W-1:0]        i_kind,
    input  wire [pba_pkg::COUNT_W-1:0]       i_page_count,
    input  wire [pba_pkg::ADDR_W-1:0]        i_address,
    input  wire [pba_pkg::TYPE_W-1:0]        i_region_type,
    input  wire [pba_pkg::SMALL_W-1:0]       i_region_small_pages,
    input  wire                              i_cfg_write,
    input  wire [pba_pkg::COUNT_W-1:0]       i_cfg_search_limit_pages,
    output logic [pba_pkg::STATUS_W-1:0]     o_status,
    output logic [pba_pkg::ADDR_W-1:0]       o_granted_address
);
    import pba_pkg::*;

    localparam logic [EXT_W-1:0] PG_MASK = (EXT_W'(1) << PAGE_SHIFT) - EXT_W'(1);

    // Request and search registers.
    logic [COUNT_W-1:0]     r_limit;
    logic [KIND_W-1:0]      r_kind;
    logic [COUNT_W-1:0]     r_count;
    logic [ADDR_W-1:0]      r_addr;
    logic [TYPE_W-1:0]      r_rtype;
    logic [SMALL_W-1:0]     r_small;
    logic [END_W-1:0]       r_first;
    logic [END_W-1:0]       r_end;
    logic                   r_fill_val;
    logic [ROW_W-1:0]       r_word;
    logic [SLICE_SEL_W-1:0] r_slice;
    logic [COUNT_W-1:0]     r_run;
    logic [STATUS_W-1:0]    r_status;
    logic [ADDR_W-1:0]      r_granted;

    // Bitmap store, one row per word, with a written flag per row.
    logic [WORD_W-1:0]      r_mem [MAP_WORDS];
    logic [WORD_W-1:0]      r_rd_data;
    logic                   r_rd_valid;
    logic [MAP_WORDS-1:0]   r_row_valid;

    logic [WORD_W-1:0]      rd_word;

    // Setup arithmetic.
    logic [ADDR_W-1:0]      first_full;
    logic [EXT_W-1:0]       end_byte;
    logic [EXT_W-1:0]       region_end;
    logic [EXT_W-1:0]       free_end;
    logic                   in_store;
    logic                   free_bad;
    logic [END_W-1:0]       clip_region_end;
    logic [END_W-1:0]       clip_free_end;

    // Slice search.
    logic [CMP_W-1:0]       lim_eff;
    logic [SLICE_W-1:0]     slice_bits;
    logic [IDX_W-1:0]       idx;
    logic [COUNT_W-1:0]     run;
    logic                   found;
    logic                   stop;
    logic [IDX_W-1:0]       fend;
    logic [CMP_W-1:0]       run_start;

    // Row marking.
    logic [END_W-1:0]       fill_last_idx;
    logic [BIT_IDX_W-1:0]   lo_off;
    logic [BIT_IDX_W-1:0]   hi_off;
    logic [WORD_W-1:0]      mask;
    logic [WORD_W-1:0]      fill_word;
    logic                   first_row;
    logic                   last_row;

    assign rd_word = r_rd_valid ? r_rd_data : reset_word(r_word);

    always_comb begin
        first_full = r_addr >> PAGE_SHIFT;
        end_byte   = {1'b0, r_addr} + (EXT_W'(r_small) << SMALL_PAGE_SHIFT);
        region_end = (end_byte >> PAGE_SHIFT) + EXT_W'(|(end_byte & PG_MASK));
        free_end   = EXT_W'(first_full) + EXT_W'(r_count);
        in_store   = first_full < ADDR_W'(NUM_PAGES);
        free_bad   = (r_count == '0) || (r_addr == '0) ||
                     ((EXT_W'(r_addr) & PG_MASK) != '0);
        clip_region_end = (region_end > EXT_W'(NUM_PAGES)) ? END_W'(NUM_PAGES)
                                                           : END_W'(region_end);
        clip_free_end   = (free_end > EXT_W'(NUM_PAGES)) ? END_W'(NUM_PAGES)
                                                         : END_W'(free_end);
    end

    // One slice of the current row is searched per cycle, between row reads; the run
    // of free pages carries over from slice to slice and from row to row.
    always_comb begin
        lim_eff    = (CMP_W'(r_limit) > CMP_W'(NUM_PAGES)) ? CMP_W'(NUM_PAGES)
                                                           : CMP_W'(r_limit);
        slice_bits = rd_word[{r_slice, {SLICE_IDX_W{1'b0}}} +: SLICE_W];
        run        = r_run;
        found      = 1'b0;
        stop       = 1'b0;
        fend       = '0;
        idx        = '0;
        for (int k = 0; k < SLICE_W; k++) begin
            idx = {r_word, r_slice, SLICE_IDX_W'(k)};
            if (!found && !stop) begin
                if (CMP_W'(idx) >= lim_eff) begin
                    stop = 1'b1;
                end else if (slice_bits[k]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (run == r_count) begin
                        found = 1'b1;
                        fend  = idx;
                    end
                end
            end
        end
        run_start = CMP_W'(fend) + CMP_W'(1) - CMP_W'(r_count);
    end

    always_comb begin
        fill_last_idx = r_end - END_W'(1);
        first_row = (r_first[END_W-1:BIT_IDX_W] == {1'b0, r_word});
        last_row  = (fill_last_idx[END_W-1:BIT_IDX_W] == {1'b0, r_word});
        lo_off    = first_row ? r_first[BIT_IDX_W-1:0] : '0;
        hi_off    = last_row ? fill_last_idx[BIT_IDX_W-1:0] : BIT_IDX_W'(WORD_W - 1);
        mask      = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (~hi_off));
        fill_word = r_fill_val ? (rd_word | mask) : (rd_word & ~mask);
    end

    always_comb begin
        o_stat.is_alloc     = (r_kind == KIND_ALLOC) && (r_count != '0);
        o_stat.slice_found  = found;
        o_stat.slice_last   = (r_slice == SLICE_SEL_W'(SLICE_CNT - 1));
        o_stat.scan_end     = stop || (o_stat.slice_last &&
                              (r_word == ROW_W'(MAP_WORDS - 1)));
        o_stat.fill_pending = (r_first < r_end);
        o_stat.fill_last    = last_row;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            r_mem[r_word] <= fill_word;
        end
        if (i_cmd.scan_rd || i_cmd.fill_rd) begin
            r_rd_data <= r_mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_limit     <= COUNT_W'(4096);
        end else begin
            if (i_cfg_write) begin
                r_limit <= i_cfg_search_limit_pages;
            end
            if (i_cmd.fill_wr) begin
                r_row_valid[r_word] <= 1'b1;
            end
            if (i_cmd.scan_rd || i_cmd.fill_rd) begin
                r_rd_valid <= r_row_valid[r_word];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_count   <= i_page_count;
            r_addr    <= i_address;
            r_rtype   <= i_region_type;
            r_small   <= i_region_small_pages;
            r_granted <= '0;
        end
        if (i_cmd.setup) begin
            r_word     <= '0;
            r_slice    <= '0;
            r_run      <= '0;
            r_first    <= '0;
            r_end      <= '0;
            r_fill_val <= 1'b1;
            r_status   <= STATUS_OK;
            case (r_kind)
                KIND_ALLOC: begin
                    if (r_count == '0) r_status <= STATUS_BAD;
                end
                KIND_FREE: begin
                    r_fill_val <= 1'b0;
                    if (free_bad) begin
                        r_status <= STATUS_BAD;
                    end else if (in_store) begin
                        r_first <= END_W'(first_full);
                        r_end   <= clip_free_end;
                        r_word  <= ROW_W'(first_full >> BIT_IDX_W);
                    end
                end
                KIND_REGION: begin
                    if (!type_is_free(r_rtype) && in_store) begin
                        r_first <= END_W'(first_full);
                        r_end   <= clip_region_end;
                        r_word  <= ROW_W'(first_full >> BIT_IDX_W);
                    end
                end
                default: begin
                    r_status <= STATUS_BAD;
                end
            endcase
        end
        if (i_cmd.scan_step) begin
            r_run   <= run;
            r_slice <= r_slice + 1'b1;
            if (found) begin
                r_first   <= END_W'(run_start);
                r_end     <= END_W'(fend) + END_W'(1);
                r_word    <= ROW_W'(run_start >> BIT_IDX_W);
                r_granted <= ADDR_W'(run_start) << PAGE_SHIFT;
            end else if (o_stat.scan_end) begin
                r_status <= STATUS_NOFIT;
            end else if (o_stat.slice_last) begin
                r_word <= r_word + 1'b1;
            end
        end
        if (i_cmd.fill_wr && !last_row) begin
            r_word <= r_word + 1'b1;
        end
    end

    assign o_status          = r_status;
    assign o_granted_address = r_granted;

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_wr |-> (r_first < r_end))
        else $error("row write outside a pending marking range");

    a_run_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (r_run < r_count))
        else $error("free run reached the count without ending the search");

endmodule

`default_nettype wire

// ===== design/page_bitmap_allocator.sv =====
// Top level of the page bitmap allocator: controller plus datapath.
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+--------------------------------------
//  request  | start, busy (transfer: start&!busy) | i_kind, i_page_count, i_address,
//           |                                    | i_region_type, i_region_small_pages
//  result   | o_done (one-cycle strobe)          | o_status, o_granted_address
//  config   | i_cfg_valid, o_cfg_ready           | i_cfg_search_limit_pages
//
// One request is in flight at a time; busy is high after the transfer through the
// result strobe, and the next transfer can come in the cycle after the strobe. Free and
// region requests go through setup, then a read and a write of each bitmap row touched,
// then the result strobe. Allocate reads the bitmap one 64-bit row at a time and searches
// it 8 pages per cycle between row reads, then reads and writes each row it marks.
// Reset is synchronous; the bitmap rows read as their reset content until first
// written, so no clearing pass is needed. Results cannot be stalled; configuration
// is taken only while busy is low.
`default_nettype none

module page_bitmap_allocator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [pba_pkg::KIND_W-1:0]        i_kind,
    input  wire [pba_pkg::COUNT_W-1:0]       i_page_count,
    input  wire [pba_pkg::ADDR_W-1:0]        i_address,
    input  wire [pba_pkg::TYPE_W-1:0]        i_region_type,
    input  wire [pba_pkg::SMALL_W-1:0]       i_region_small_pages,
    output logic                             o_done,
    output logic [pba_pkg::STATUS_W-1:0]     o_status,
    output logic [pba_pkg::ADDR_W-1:0]       o_granted_address,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [pba_pkg::COUNT_W-1:0]       i_cfg_search_limit_pages
);
    import pba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pba_datapath u_datapath (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (cmd),
        .o_stat                   (stat),
        .i_kind                   (i_kind),
        .i_page_count             (i_page_count),
        .i_address                (i_address),
        .i_region_type            (i_region_type),
        .i_region_small_pages     (i_region_small_pages),
        .i_cfg_write              (i_cfg_valid && o_cfg_ready),
        .i_cfg_search_limit_pages (i_cfg_search_limit_pages),
        .o_status                 (o_status),
        .o_granted_address        (o_granted_address)
    );

    assign o_done      = cmd.done;
    assign o_cfg_ready = !busy;

endmodule

`default_nettype wire

// ===== tb/sv/page_bitmap_allocator_tb.sv =====
// Self-checking testbench of the page bitmap allocator: directed and random requests.
`timescale 1ns / 100ps

module page_bitmap_allocator_tb;
    import pba_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REFILL_LEVEL = 3000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
    } t_grant;

    typedef struct {
        int first;
        int pages;
    } t_page_run;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [KIND_W-1:0]    req_kind;
    logic [COUNT_W-1:0]   req_page_count;
    logic [ADDR_W-1:0]    req_address;
    logic [TYPE_W-1:0]    req_region_type;
    logic [SMALL_W-1:0]   req_region_pages;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_W-1:0]    o_granted_address;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_search_limit_pages;

    // Shadow copy of the allocator state.
    bit [NUM_PAGES-1:0]   used_pages;
    int                   limit_pages;

    t_grant               pending_grants[$];
    t_page_run            granted_runs[$];
    int                   sender_idle_pct;
    int                   failures;
    int                   cycle_count;

    page_bitmap_allocator dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_kind                  (req_kind),
        .i_page_count            (req_page_count),
        .i_address               (req_address),
        .i_region_type           (req_region_type),
        .i_region_small_pages    (req_region_pages),
        .o_done                  (o_done),
        .o_status                (o_status),
        .o_granted_address       (o_granted_address),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_search_limit_pages(i_cfg_search_limit_pages)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void mark_pages(input logic [63:0] first_pg, input logic [63:0] end_pg,
                                       input bit value);
        for (logic [63:0] p = first_pg; p < end_pg && p < NUM_PAGES; p++) begin
            used_pages[p] = value;
        end
    endfunction

    // Applies one request to the shadow bitmap and returns the answer it must produce.
    function automatic t_grant predict_grant(input logic [KIND_W-1:0] kind,
                                             input logic [COUNT_W-1:0] page_count,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [TYPE_W-1:0] rtype,
                                             input logic [SMALL_W-1:0] region_pages);
        t_grant      g;
        int          lim;
        int          run;
        int          first;
        logic [63:0] end_byte;
        logic [63:0] first_pg;
        logic [63:0] end_pg;
        g.status  = STATUS_OK;
        g.granted = '0;
        case (kind)
            KIND_ALLOC: begin
                lim   = (limit_pages > NUM_PAGES) ? NUM_PAGES : limit_pages;
                run   = 0;
                first = -1;
                if (page_count == 0) begin
                    g.status = STATUS_BAD;
                end else begin
                    for (int i = 0; i < lim && first < 0; i++) begin
                        if (used_pages[i]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == int'(page_count)) first = i + 1 - run;
                        end
                    end
                    if (first < 0) begin
                        g.status = STATUS_NOFIT;
                    end else begin
                        mark_pages(64'(first), 64'(first) + 64'(page_count), 1'b1);
                        g.granted = ADDR_W'(first) << PAGE_SHIFT;
                    end
                end
            end
            KIND_FREE: begin
                if (page_count == 0 || addr == 0 || addr[PAGE_SHIFT-1:0] != 0) begin
                    g.status = STATUS_BAD;
                end else begin
                    first_pg = 64'(addr) >> PAGE_SHIFT;
                    mark_pages(first_pg, first_pg + 64'(page_count), 1'b0);
                end
            end
            KIND_REGION: begin
                if (!(rtype inside {TYPE_LOADER_CODE, TYPE_BOOT_SVC_CODE,
                                    TYPE_BOOT_SVC_DATA, TYPE_CONVENTIONAL})) begin
                    end_byte = 64'(addr) + (64'(region_pages) << SMALL_PAGE_SHIFT);
                    first_pg = 64'(addr) >> PAGE_SHIFT;
                    end_pg   = (end_byte >> PAGE_SHIFT) +
                               ((end_byte[PAGE_SHIFT-1:0] != 0) ? 64'd1 : 64'd0);
                    mark_pages(first_pg, end_pg, 1'b1);
                end
            end
            default: g.status = STATUS_BAD;
        endcase
        return g;
    endfunction

    // Called and returning at a falling edge; start is left high for a back-to-back request.
    task automatic issue_request(input logic [KIND_W-1:0] kind,
                                 input logic [COUNT_W-1:0] page_count,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [TYPE_W-1:0] rtype,
                                 input logic [SMALL_W-1:0] region_pages);
        int        gap;
        t_grant    g;
        t_page_run r;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start            <= 1'b1;
        req_kind         <= kind;
        req_page_count   <= page_count;
        req_address      <= addr;
        req_region_type  <= rtype;
        req_region_pages <= region_pages;
        do @(posedge i_clk); while (busy);
        g = predict_grant(kind, page_count, addr, rtype, region_pages);
        pending_grants.push_back(g);
        if (kind == KIND_ALLOC && g.status == STATUS_OK) begin
            r.first = int'(g.granted >> PAGE_SHIFT);
            r.pages = int'(page_count);
            granted_runs.push_back(r);
        end
        @(negedge i_clk);
    endtask

    // The limit register is only written once every request has been answered.
    task automatic write_search_limit(input logic [COUNT_W-1:0] value);
        start <= 1'b0;
        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid              <= 1'b1;
        i_cfg_search_limit_pages <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_pages = int'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_allocate_edges();
        issue_request(KIND_ALLOC, 13'd1, '0, '0, '0);
        issue_request(KIND_ALLOC, 13'd0, '0, '0, '0);
        issue_request(KIND_ALLOC, 13'd8191, '0, '0, '0);
        // Takes every page that is still free, so the next single page cannot fit.
        issue_request(KIND_ALLOC, 13'd4092, '0, '0, '0);
        issue_request(KIND_ALLOC, 13'd1, '0, '0, '0);
        issue_request(KIND_FREE, 13'd4092, ADDR_W'(4) << PAGE_SHIFT, '0, '0);
        issue_request(KIND_UNUSED, '1, '1, '1, '1);
    endtask

    task automatic test_free_requests();
        issue_request(KIND_FREE, 13'd0, ADDR_W'(8) << PAGE_SHIFT, '0, '0);
        issue_request(KIND_FREE, 13'd1, '0, '0, '0);
        issue_request(KIND_FREE, 13'd1, (ADDR_W'(3) << PAGE_SHIFT) | 52'd1, '0, '0);
        issue_request(KIND_FREE, 13'd1, (ADDR_W'(3) << PAGE_SHIFT) | (52'd1 << 20), '0, '0);
        issue_request(KIND_FREE, 13'd8191, {{(ADDR_W-PAGE_SHIFT){1'b1}}, {PAGE_SHIFT{1'b0}}},
                      '0, '0);
        issue_request(KIND_FREE, 13'd8191, ADDR_W'(NUM_PAGES - 1) << PAGE_SHIFT, '0, '0);
        // Pages that are used from reset may be released too.
        issue_request(KIND_FREE, 13'd3, ADDR_W'(1) << PAGE_SHIFT, '0, '0);
        issue_request(KIND_ALLOC, 13'd2, '0, '0, '0);
    endtask

    task automatic test_region_marking();
        issue_request(KIND_REGION, '0, (ADDR_W'(5) << PAGE_SHIFT) + 52'd123, 4'd0, '0);
        issue_request(KIND_REGION, '0, ADDR_W'(20) << PAGE_SHIFT, TYPE_CONVENTIONAL, 40'd4096);
        issue_request(KIND_REGION, '0, ADDR_W'(10) << PAGE_SHIFT, 4'd15, 40'd1537);
        issue_request(KIND_REGION, '0, '1, 4'd15, '1);
        issue_request(KIND_REGION, '0, ADDR_W'(4000) << PAGE_SHIFT, 4'd2, '1);
        issue_request(KIND_ALLOC, 13'd4, '0, '0, '0);
        issue_request(KIND_FREE, 13'd4093, ADDR_W'(3) << PAGE_SHIFT, '0, '0);
    endtask

    task automatic test_search_limit();
        write_search_limit(13'd0);
        issue_request(KIND_ALLOC, 13'd1, '0, '0, '0);
        write_search_limit(13'd1);
        issue_request(KIND_ALLOC, 13'd1, '0, '0, '0);
        // A limit above the store size is clipped to the store.
        write_search_limit(13'd8191);
        issue_request(KIND_ALLOC, 13'd4093, '0, '0, '0);
        issue_request(KIND_FREE, 13'd4093, ADDR_W'(3) << PAGE_SHIFT, '0, '0);
    endtask

    task automatic test_random_traffic();
        int                 idle_pct[4];
        int                 pick;
        int                 sel;
        int                 idx;
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] cnt;
        logic [ADDR_W-1:0]  addr;
        logic [TYPE_W-1:0]  rtype;
        logic [SMALL_W-1:0] len;
        logic [COUNT_W-1:0] limit_value;
        idle_pct = '{0, 80, 0, 34};
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       limit_value = 13'(NUM_PAGES);
                2:       limit_value = 13'd8191;
                default: limit_value = 13'($urandom_range(256, NUM_PAGES));
            endcase
            sender_idle_pct = 0;
            write_search_limit(limit_value);
            sender_idle_pct = idle_pct[phase];
            for (int n = 0; n < 100; n++) begin
                if ($countones(used_pages) > REFILL_LEVEL) begin
                    issue_request(KIND_FREE, 13'(NUM_PAGES - RESET_USED),
                                  ADDR_W'(RESET_USED) << PAGE_SHIFT, '0, '0);
                    granted_runs.delete();
                    continue;
                end
                pick  = $urandom_range(99);
                cnt   = '0;
                addr  = ADDR_W'({$urandom, $urandom});
                rtype = 4'($urandom);
                len   = SMALL_W'({$urandom, $urandom});
                if (pick < 40) begin
                    kind = KIND_ALLOC;
                    sel  = $urandom_range(99);
                    if (sel < 70)      cnt = 13'($urandom_range(1, 4));
                    else if (sel < 90) cnt = 13'($urandom_range(5, 64));
                    else if (sel < 97) cnt = 13'($urandom_range(65, 1024));
                    else if (sel < 99) cnt = 13'($urandom_range(0, 8191));
                end else if (pick < 70) begin
                    kind = KIND_FREE;
                    sel  = $urandom_range(99);
                    if (granted_runs.size() > 0 && sel < 75) begin
                        idx  = $urandom_range(granted_runs.size() - 1);
                        addr = ADDR_W'(granted_runs[idx].first) << PAGE_SHIFT;
                        cnt  = 13'(granted_runs[idx].pages);
                        granted_runs.delete(idx);
                    end else begin
                        cnt = 13'($urandom_range(0, 64));
                        if (sel < 85) addr = ADDR_W'($urandom_range(0, NUM_PAGES)) << PAGE_SHIFT;
                        else if (sel < 93) cnt = 13'($urandom_range(0, 8191));
                        // The low address bits are cleared on roughly half of these requests.
                        if ($urandom_range(1)) addr[PAGE_SHIFT-1:0] = '0;
                    end
                end else if (pick < 93) begin
                    kind = KIND_REGION;
                    sel  = $urandom_range(99);
                    if (sel >= 3) begin
                        addr = ADDR_W'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT;
                        if (sel < 50) addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
                        len = 40'($urandom_range(0, 2048));
                    end else if (sel == 0) begin
                        addr = ADDR_W'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT;
                    end
                end else begin
                    kind = KIND_UNUSED;
                    cnt  = 13'($urandom);
                end
                issue_request(kind, cnt, addr, rtype, len);
            end
        end
    endtask

    // Every result strobe is matched against the oldest outstanding answer.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_done) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result: status %0d, granted_address 0x%0h",
                       o_status, o_granted_address);
                failures++;
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status) begin
                    $error("field status: expected %0d, actual %0d", want.status, o_status);
                    failures++;
                end
                if (o_granted_address !== want.granted) begin
                    $error("field granted_address: expected 0x%0h, actual 0x%0h",
                           want.granted, o_granted_address);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n                  = 1'b0;
        start                    = 1'b0;
        req_kind                 = '0;
        req_page_count           = '0;
        req_address              = '0;
        req_region_type          = '0;
        req_region_pages         = '0;
        i_cfg_valid              = 1'b0;
        i_cfg_search_limit_pages = '0;
        used_pages               = '0;
        used_pages[RESET_USED-1:0] = '1;
        limit_pages              = NUM_PAGES;
        sender_idle_pct          = 0;
        failures                 = 0;
        cycle_count              = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_allocate_edges();
        test_free_requests();
        test_region_marking();
        test_search_limit();
        test_random_traffic();

        start <= 1'b0;
        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
